@@ hdl/slpd_pkg.sv @@
// Shared types and constants for the scan line PackBits run decoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package slpd_pkg;

	localparam int PPL_W    = 15;
	localparam int BUDGET_W = 16;
	localparam int COUNT_W  = 16;
	localparam int BYTE_W   = 8;

	localparam logic [BYTE_W-1:0]   NOOP_HEADER = 8'h80;
	localparam logic [BUDGET_W-1:0] BUDGET_MAX  = 16'hFFFF;

	// configuration register indexes
	localparam logic REG_PIXELS   = 1'b0;
	localparam logic REG_CHANNELS = 1'b1;

	typedef enum logic [1:0] {
		KIND_BLANK    = 2'd0,
		KIND_PACKBITS = 2'd1,
		KIND_RAW      = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_LITERAL = 3'b010,
		PH_REPEAT  = 3'b100
	} phase_t;

	typedef struct packed {
		logic                valid;
		logic [BYTE_W-1:0]   value;
		logic [COUNT_W-1:0]  count;
		logic                done;
	} slpd_result_t;

endpackage
`default_nettype wire

@@ hdl/scan_line_packbits_decoder_unit.sv @@
// A byte is decoded from the input register into the output register.
// Throughput: one byte per cycle; the input stalls only while a finished
// run waits in the output register and the output is stalled.
// Reset (arst_n low): valid flags, configuration and line state cleared, no line open, header expected.
// Top level: input register, decode step, output register. Uses slpd_pkg.
`default_nettype none
module scan_line_packbits_decoder_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic                           cfg_index,
	input  wire logic [slpd_pkg::PPL_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     kind,
	input  wire logic [slpd_pkg::BYTE_W-1:0]    data_byte,
	input  wire logic                           line_end,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [slpd_pkg::BYTE_W-1:0]         run_value,
	output logic [slpd_pkg::COUNT_W-1:0]        run_count,
	output logic                                line_done
);
	import slpd_pkg::*;

	logic                valid_s1;
	logic [1:0]          kind_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                end_s1;
	logic                valid_s2;
	logic [BYTE_W-1:0]   value_s2;
	logic [COUNT_W-1:0]  count_s2;
	logic                done_s2;
	logic                out_blocked, adv;
	logic [BUDGET_W-1:0] line_budget;
	slpd_result_t        res;

	assign cfg_ready   = 1'b1;
	assign out_blocked = valid_s2 && out_stall;
	assign adv         = valid_s1 && !out_blocked;
	assign in_stall    = valid_s1 && out_blocked;

	slpd_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.line_budget (line_budget)
	);

	slpd_decode u_dec (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.kind        (kind_s1),
		.data_byte   (byte_s1),
		.line_end    (end_s1),
		.line_budget (line_budget),
		.result      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (!out_blocked)
				valid_s2 <= adv && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			byte_s1 <= data_byte;
			end_s1  <= line_end;
		end
		if (adv && res.valid) begin
			value_s2 <= res.value;
			count_s2 <= res.count;
			done_s2  <= res.done;
		end
	end

	assign out_valid = valid_s2;
	assign run_value = value_s2;
	assign run_count = count_s2;
	assign line_done = done_s2;

endmodule
`default_nettype wire

@@ hdl/slpd_cfg_regs.sv @@
// Configuration registers and the derived line budget (pixels, tripled in
// three-channel mode, saturated to 16 bits). Depends on slpd_pkg.
`default_nettype none
module slpd_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_index,
	input  wire logic [slpd_pkg::PPL_W-1:0]     cfg_data,
	output logic [slpd_pkg::BUDGET_W-1:0]       line_budget
);
	import slpd_pkg::*;

	logic [PPL_W-1:0] ppl_q;
	logic             three_q;
	logic [PPL_W+1:0] sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppl_q   <= '0;
			three_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PIXELS:   ppl_q   <= cfg_data;
				REG_CHANNELS: three_q <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	// x3 as x + 2x
	always_comb begin
		sum = {2'b00, ppl_q};
		if (three_q)
			sum = sum + {1'b0, ppl_q, 1'b0};
	end

	assign line_budget = (sum > {1'b0, BUDGET_MAX}) ? BUDGET_MAX : sum[BUDGET_W-1:0];

endmodule
`default_nettype wire

@@ hdl/slpd_decode.sv @@
// Line state (budget, phase, run length, line open) and the one-byte
// decode step producing at most one run. Depends on slpd_pkg.
`default_nettype none
module slpd_decode (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step,
	input  wire logic [1:0]                     kind,
	input  wire logic [slpd_pkg::BYTE_W-1:0]    data_byte,
	input  wire logic                           line_end,
	input  wire logic [slpd_pkg::BUDGET_W-1:0]  line_budget,
	output slpd_pkg::slpd_result_t              result
);
	import slpd_pkg::*;

	logic [BUDGET_W-1:0] budget_q, budget_d, bl;
	phase_t              phase_q, phase_d, ph;
	logic [BYTE_W-1:0]   run_q, run_d, rl;
	logic                open_q, open_d;
	logic [BUDGET_W-1:0] rep_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= '0;
			phase_q  <= PH_HEADER;
			run_q    <= '0;
			open_q   <= 1'b0;
		end else if (step) begin
			budget_q <= budget_d;
			phase_q  <= phase_d;
			run_q    <= run_d;
			open_q   <= open_d;
		end
	end

	// a closed line restarts from the configured budget
	assign bl = open_q ? budget_q : line_budget;
	assign ph = open_q ? phase_q : PH_HEADER;
	assign rl = open_q ? run_q : '0;
	assign rep_cnt = ({{(BUDGET_W-BYTE_W){1'b0}}, rl} < bl) ?
		{{(BUDGET_W-BYTE_W){1'b0}}, rl} : bl;

	always_comb begin
		budget_d = budget_q;
		phase_d  = phase_q;
		run_d    = run_q;
		open_d   = open_q;
		result   = '0;
		case (kind)
			KIND_BLANK: begin
				open_d   = 1'b0;
				phase_d  = PH_HEADER;
				run_d    = '0;
				budget_d = '0;
				result.valid = (line_budget != '0);
				result.count = line_budget;
				result.done  = 1'b1;
			end
			KIND_RAW: begin
				open_d  = 1'b0;
				phase_d = PH_HEADER;
				run_d   = '0;
				result.valid = 1'b1;
				result.value = data_byte;
				result.count = {{(COUNT_W-1){1'b0}}, 1'b1};
				result.done  = line_end;
			end
			KIND_PACKBITS: begin
				budget_d = bl;
				phase_d  = ph;
				run_d    = rl;
				open_d   = 1'b1;
				case (ph)
					PH_HEADER: begin
						if (!data_byte[BYTE_W-1]) begin
							run_d   = data_byte + 1'b1;
							phase_d = PH_LITERAL;
						end else if (data_byte != NOOP_HEADER) begin
							// 257 - n, modulo 256
							run_d   = 8'd1 - data_byte;
							phase_d = PH_REPEAT;
						end
					end
					PH_LITERAL: begin
						if (bl != '0) begin
							budget_d = bl - 1'b1;
							result.valid = 1'b1;
							result.value = data_byte;
							result.count = {{(COUNT_W-1){1'b0}}, 1'b1};
							result.done  = (budget_d == '0) || line_end;
						end
						run_d = rl - 1'b1;
						if (run_d == '0)
							phase_d = PH_HEADER;
					end
					PH_REPEAT: begin
						if (rep_cnt != '0) begin
							budget_d = bl - rep_cnt;
							result.valid = 1'b1;
							result.value = data_byte;
							result.count = rep_cnt;
							result.done  = (budget_d == '0) || line_end;
						end
						run_d   = '0;
						phase_d = PH_HEADER;
					end
					default: phase_d = PH_HEADER;
				endcase
				if (line_end) begin
					open_d  = 1'b0;
					phase_d = PH_HEADER;
					run_d   = '0;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/slpd_checker.sv @@
// Port-level checks for the scan line PackBits run decoder, bound to the
// top level. Depends on slpd_pkg and scan_line_packbits_decoder_unit.
`default_nettype none
module slpd_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_stall,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic [slpd_pkg::BYTE_W-1:0]    run_value,
	input wire logic [slpd_pkg::COUNT_W-1:0]   run_count,
	input wire logic                           line_done
);
	import slpd_pkg::*;

	// a stalled run holds until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(run_value) &&
		$stable(run_count) && $stable(line_done))
		else $error("stalled run changed");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> run_count != '0)
		else $error("run with zero count");

	// input back-pressure only comes from a blocked output
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without blocked output");

	// only blank lines make runs longer than a PackBits repeat
	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_count > 16'd128 |-> run_value == '0 && line_done)
		else $error("long run that is not a blank line");

endmodule

bind scan_line_packbits_decoder_unit slpd_checker u_chk (.*);
`default_nettype wire
